/* hdl/assert_macros.svh */
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold on every rising edge outside reset.
`define A_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Antecedent implies consequent on the next edge.
`define A_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define A_ALWAYS(lbl, clk, rstn, prop, msg)
`define A_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* hdl/vsmp_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vsmp_pkg
// Types and codes for the vertex skinning block.
// ---------------------------------------------------------------------------
package vsmp_pkg;
    typedef enum logic [1:0] {
        MODE_PAL_WR = 2'd0,
        MODE_FRAME  = 2'd1,
        MODE_ASSIGN = 2'd2,
        MODE_REPORT = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_BOX_LO = 2'd1,
        KIND_BOX_HI = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MREAD,
        ST_MULT,
        ST_SUM,
        ST_WMUL,
        ST_WSAT,
        ST_ACC,
        ST_EMIT,
        ST_BOXLO,
        ST_BOXHI
    } t_state;

    localparam int unsigned ELEMS = 12;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647)
            sat32 = 32'sh7FFFFFFF;
        else if (x < -66'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = x[31:0];
    endfunction
endpackage

/* hdl/vertex_skinning_matrix_palette.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vertex_skinning_matrix_palette
// Linear blend skinning over a bone matrix palette, fixed point.
// ---------------------------------------------------------------------------
// One item is handled at a time. After reset the block sweeps the touched-mark
// memory one entry a cycle and keeps its input closed until the sweep is done.
// A palette write leaves the input open. A frame start is taken and then
// keeps the input closed while it clears the touched marks. An assignment
// keeps the input closed from when it is taken until its result is loaded.
// The twelve matrix words are read from the palette memory, one per cycle.
// Each of the three rows then runs its six products through one shared
// 32x32 multiplier, adds the translation, applies the two weight
// multipliers, passes a spare step, and does the read-modify-write of the
// accumulator memories. The final step loads the result. A box report keeps
// the input closed while its low and high box words are loaded in turn.
// Results wait in one output register. The input reopens as soon as the last
// result of an item is loaded there. A result that finds the register still
// full waits until the earlier word has been taken.
`include "assert_macros.svh"
module vertex_skinning_matrix_palette
    import vsmp_pkg::*;
#(
    parameter int BONES     = 64,
    parameter int VERTICES  = 4096,
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // bone_index[5:0], element_index[9:6], element_value[41:10],
    // vertex_index[53:42], weight[70:54], src_x..z[166:71], norm_x..z[262:167]
    input  logic [263:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_vertex[11:0], out_x,y,z[107:12], out_nx,ny,nz[203:108]
    output logic [207:0] m_axis_tdata,
    // kind[1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    localparam int PW = $clog2(BONES * ELEMS);
    localparam int VW = $clog2(VERTICES);
    localparam int AW = $clog2(VERTICES * 4);

    t_state r_state, n_state;

    logic [5:0]         r_bone;
    logic [VW-1:0]      r_vtx;
    logic               r_vtx_ok;
    logic [16:0]        r_w;
    logic signed [31:0] r_src [6];
    logic signed [31:0] r_m [ELEMS];
    logic [3:0]         r_ecnt;
    logic [1:0]         r_row;
    logic [2:0]         r_pcnt;
    logic signed [65:0] r_ps, r_ns;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_tp, r_tn;
    logic signed [31:0] r_np [3];
    logic signed [31:0] r_nn [3];
    logic signed [31:0] r_blo [3];
    logic signed [31:0] r_bhi [3];
    logic               r_empty;
    logic [VW-1:0]      r_clr;
    logic               r_out_v;
    logic [207:0]       r_out_d;
    logic [1:0]         r_out_k;
    logic               r_out_l;

    // Memories.
    logic [31:0] mem_pal [BONES*ELEMS];
    logic [31:0] mem_accp [VERTICES*4];
    logic [31:0] mem_accn [VERTICES*4];
    logic        mem_tch [VERTICES];
    logic [31:0] r_pal_q, r_accp_q, r_accn_q;
    logic        r_tch_q;

    logic        acc;
    logic [1:0]  in_mode;
    logic [5:0]  in_bone;
    logic [3:0]  in_elem;
    logic [11:0] in_vtx;
    assign acc     = s_axis_tvalid & s_axis_tready;
    assign in_mode = s_axis_tuser;
    assign in_bone = s_axis_tdata[5:0];
    assign in_elem = s_axis_tdata[9:6];
    assign in_vtx  = s_axis_tdata[53:42];

    logic        bone_ok;
    assign bone_ok = 32'(r_bone) < 32'(BONES);

    logic [PW-1:0] pal_raddr;
    assign pal_raddr = PW'(32'(r_bone) * ELEMS + 32'(r_ecnt));
    logic [AW-1:0] acc_addr;
    assign acc_addr = {r_vtx, r_row};

    // Current multiplier operands: products c = 0..2 for position, 3..5 normal.
    logic signed [31:0] mul_a, mul_b;
    logic [1:0] col;
    always_comb begin
        col = (r_pcnt >= 3'd3) ? 2'(r_pcnt - 3'd3) : r_pcnt[1:0];
        mul_a = r_m[4'(col) * 4'd3 + 4'(r_row)];
        mul_b = r_src[3'(r_pcnt)];
    end

    logic signed [63:0] w_prod_p, w_prod_n;
    assign w_prod_p = 64'(r_tp) * $signed({15'd0, r_w});
    assign w_prod_n = 64'(r_tn) * $signed({15'd0, r_w});

    logic signed [31:0] sum_p, sum_n;
    always_comb begin
        sum_p = sat32(66'(r_tp) + 66'($signed(r_accp_q)));
        sum_n = sat32(66'(r_tn) + 66'($signed(r_accn_q)));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    case (t_mode'(in_mode))
                        MODE_FRAME:  n_state = ST_CLEAR;
                        MODE_ASSIGN: n_state = (32'(in_vtx) < 32'(VERTICES)) ?
                                               ST_MREAD : ST_IDLE;
                        MODE_REPORT: n_state = ST_BOXLO;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: if (32'(r_clr) == 32'(VERTICES - 1)) n_state = ST_IDLE;
            ST_MREAD: if (r_ecnt == 4'd12) n_state = ST_MULT;
            ST_MULT:  if (r_pcnt == 3'd6) n_state = ST_SUM;
            ST_SUM:   n_state = ST_WMUL;
            ST_WMUL:  n_state = ST_WSAT;
            ST_WSAT:  n_state = ST_ACC;
            ST_ACC:   n_state = (r_row == 2'd2) ? ST_EMIT : ST_MULT;
            ST_EMIT:  if (!r_out_v) n_state = ST_IDLE;
            ST_BOXLO: if (!r_out_v) n_state = ST_BOXHI;
            ST_BOXHI: if (!r_out_v) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs of the controller.
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
    end

    // Reset starts with a sweep that clears every touched mark.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_CLEAR;
        else          r_state <= n_state;
    end

    // Memory ports.
    always_ff @(posedge i_clk) begin
        r_pal_q <= mem_pal[pal_raddr];
        if (acc && t_mode'(in_mode) == MODE_PAL_WR && in_elem < 4'd12 &&
            32'(in_bone) < 32'(BONES))
            mem_pal[PW'(32'(in_bone) * ELEMS + 32'(in_elem))] <= s_axis_tdata[41:10];
    end

    always_ff @(posedge i_clk) begin
        r_accp_q <= mem_accp[acc_addr];
        r_accn_q <= mem_accn[acc_addr];
        if (r_state == ST_ACC) begin
            mem_accp[acc_addr] <= r_tch_q ? sum_p : r_tp;
            mem_accn[acc_addr] <= r_tch_q ? sum_n : r_tn;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tch_q <= mem_tch[r_vtx];
        if (r_state == ST_CLEAR)
            mem_tch[r_clr] <= 1'b0;
        else if (r_state == ST_EMIT && !r_out_v)
            mem_tch[r_vtx] <= 1'b1;
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty <= 1'b1;
            r_clr   <= '0;
            r_out_v <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_blo[i] <= '0;
                r_bhi[i] <= '0;
            end
        end else begin
            if (m_axis_tready && r_out_v) r_out_v <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    r_ecnt <= '0;
                    r_row  <= '0;
                    r_pcnt <= '0;
                    r_clr  <= '0;
                    if (acc) begin
                        r_bone <= in_bone;
                        r_vtx  <= VW'(in_vtx);
                        r_w    <= s_axis_tdata[70:54];
                        for (int i = 0; i < 6; i++)
                            r_src[i] <= s_axis_tdata[71 + 32*i +: 32];
                        if (t_mode'(in_mode) == MODE_FRAME) begin
                            r_empty <= 1'b1;
                            for (int i = 0; i < 3; i++) begin
                                r_blo[i] <= '0;
                                r_bhi[i] <= '0;
                            end
                        end
                    end
                end
                ST_CLEAR: r_clr <= r_clr + 1'b1;
                ST_MREAD: begin
                    // Read data arrives in the cycle after the address.
                    if (r_ecnt != 4'd0)
                        r_m[r_ecnt - 4'd1] <= bone_ok ? r_pal_q : 32'd0;
                    r_ecnt <= r_ecnt + 4'd1;
                    r_ps <= '0;
                    r_ns <= '0;
                end
                ST_MULT: begin
                    r_prod <= 64'(mul_a) * 64'(mul_b);
                    if (r_pcnt != 3'd0) begin
                        if (r_pcnt <= 3'd3) r_ps <= r_ps + 66'(r_prod >>> FRAC_BITS);
                        else                r_ns <= r_ns + 66'(r_prod >>> FRAC_BITS);
                    end
                    r_pcnt <= r_pcnt + 3'd1;
                end
                ST_SUM: begin
                    r_tp <= sat32(r_ps + 66'(r_m[4'd9 + 4'(r_row)]));
                    r_tn <= sat32(r_ns);
                end
                ST_WMUL: begin
                    r_tp <= sat32(66'(w_prod_p >>> FRAC_BITS));
                    r_tn <= sat32(66'(w_prod_n >>> FRAC_BITS));
                end
                ST_WSAT: ; // accumulator read and touched mark settle here
                ST_ACC: begin
                    r_np[r_row] <= r_tch_q ? sum_p : r_tp;
                    r_nn[r_row] <= r_tch_q ? sum_n : r_tn;
                    r_row  <= r_row + 2'd1;
                    r_pcnt <= '0;
                    r_ps   <= '0;
                    r_ns   <= '0;
                end
                ST_EMIT: if (!r_out_v) begin
                    r_out_v <= 1'b1;
                    r_out_k <= KIND_VERTEX;
                    r_out_l <= 1'b1;
                    r_out_d <= {4'd0, r_nn[2], r_nn[1], r_nn[0], r_np[2], r_np[1],
                                r_np[0], 12'(r_vtx)};
                    for (int i = 0; i < 3; i++) begin
                        if (r_empty || r_np[i] < r_blo[i]) r_blo[i] <= r_np[i];
                        if (r_empty || r_np[i] > r_bhi[i]) r_bhi[i] <= r_np[i];
                    end
                    r_empty <= 1'b0;
                end
                ST_BOXLO: if (!r_out_v) begin
                    r_out_v <= 1'b1;
                    r_out_k <= KIND_BOX_LO;
                    r_out_l <= 1'b0;
                    r_out_d <= {100'd0, r_blo[2], r_blo[1], r_blo[0], 12'd0};
                end
                ST_BOXHI: if (!r_out_v) begin
                    r_out_v <= 1'b1;
                    r_out_k <= KIND_BOX_HI;
                    r_out_l <= 1'b1;
                    r_out_d <= {100'd0, r_bhi[2], r_bhi[1], r_bhi[0], 12'd0};
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_d;
    assign m_axis_tuser  = r_out_k;
    assign m_axis_tlast  = r_out_l;

    `A_ALWAYS(a_ready_idle, i_clk, i_rst_n, !(s_axis_tready && r_state != ST_IDLE), "ready")
    `A_NEXT(a_hi_after_lo, i_clk, i_rst_n, r_state == ST_BOXLO && !r_out_v, r_state == ST_BOXHI, "box")
    `A_NEXT(a_clear_empty, i_clk, i_rst_n, acc && t_mode'(in_mode) == MODE_FRAME, r_empty, "empty")
    `A_ALWAYS(a_box_order, i_clk, i_rst_n, r_empty || (r_blo[0] <= r_bhi[0]), "box inverted")
endmodule

/* verif/vertex_skinning_matrix_palette_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vertex_skinning_matrix_palette_test
// Stream-level test of the skinning block. A local predictor tracks the
// palette, touched marks, accumulators and bounding box and produces the
// expected output words. Each output word is checked as a whole against the
// oldest expected word, under several idle and stall patterns.
// ---------------------------------------------------------------------------
module vertex_skinning_matrix_palette_test;
    import vsmp_pkg::*;

    localparam int NBONES = 64;
    localparam int NVERTS = 4096;
    localparam int FRAC   = 16;
    localparam int STALL_LIMIT = 40000;

    typedef struct packed {
        t_kind              kind;
        logic [11:0]        vtx;
        logic signed [31:0] x, y, z, nx, ny, nz;
        logic               last;
    } t_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [263:0] s_axis_tdata;  // bone, element, value, vertex, weight, src xyz, norm xyz
    logic [1:0]   s_axis_tuser;  // mode
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [207:0] m_axis_tdata;  // vertex, x, y, z, nx, ny, nz
    logic [1:0]   m_axis_tuser;  // kind
    logic         m_axis_tlast;

    vertex_skinning_matrix_palette dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Predictor state.
    logic signed [31:0] pal_mem [NBONES*12];
    bit                 vtx_touched [NVERTS];
    logic signed [31:0] pos_acc [NVERTS*3];
    logic signed [31:0] nrm_acc [NVERTS*3];
    logic signed [31:0] bbox_lo [3];
    logic signed [31:0] bbox_hi [3];
    bit                 bbox_empty;

    t_result expected_words[$];
    int      mismatches;
    int      idle_pct;
    int      stall_pct;
    bit      hold_off;
    int      quiet_cycles;
    bit      timed_out;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] fx_shift(input logic signed [63:0] v);
        return v >>> FRAC;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    task automatic skin_predict(input t_mode mode, input logic [5:0] bone,
                                input logic [3:0] elem, input logic signed [31:0] val,
                                input logic [11:0] vtx, input logic [16:0] wgt,
                                input logic signed [31:0] sp [3],
                                input logic signed [31:0] sn [3]);
        logic signed [63:0] mat [12];
        logic signed [63:0] ps, ns, tp, tn;
        logic signed [31:0] np [3];
        logic signed [31:0] nn [3];
        t_result res;
        case (mode)
            MODE_PAL_WR: begin
                if (elem < 12 && bone < NBONES)
                    pal_mem[bone*12+elem] = val;
            end
            MODE_FRAME: begin
                foreach (vtx_touched[i]) vtx_touched[i] = 1'b0;
                for (int i = 0; i < 3; i++) begin
                    bbox_lo[i] = '0;
                    bbox_hi[i] = '0;
                end
                bbox_empty = 1'b1;
            end
            MODE_REPORT: begin
                res = '{KIND_BOX_LO, 12'd0, bbox_lo[0], bbox_lo[1], bbox_lo[2], 0, 0, 0, 1'b0};
                expected_words.push_back(res);
                res = '{KIND_BOX_HI, 12'd0, bbox_hi[0], bbox_hi[1], bbox_hi[2], 0, 0, 0, 1'b1};
                expected_words.push_back(res);
            end
            default: begin
                for (int c = 0; c < 12; c++)
                    mat[c] = (bone < NBONES) ? 64'(pal_mem[bone*12+c]) : 64'sd0;
                for (int r = 0; r < 3; r++) begin
                    ps = mat[9+r];
                    ns = '0;
                    for (int c = 0; c < 3; c++) begin
                        ps += fx_shift(mat[c*3+r] * 64'(sp[c]));
                        ns += fx_shift(mat[c*3+r] * 64'(sn[c]));
                    end
                    tp = 64'(clamp32(fx_shift(64'(clamp32(ps)) * $signed({47'd0, wgt}))));
                    tn = 64'(clamp32(fx_shift(64'(clamp32(ns)) * $signed({47'd0, wgt}))));
                    if (vtx_touched[vtx]) begin
                        tp = 64'(clamp32(tp + 64'(pos_acc[vtx*3+r])));
                        tn = 64'(clamp32(tn + 64'(nrm_acc[vtx*3+r])));
                    end
                    pos_acc[vtx*3+r] = tp[31:0];
                    nrm_acc[vtx*3+r] = tn[31:0];
                    np[r] = tp[31:0];
                    nn[r] = tn[31:0];
                end
                vtx_touched[vtx] = 1'b1;
                for (int r = 0; r < 3; r++) begin
                    if (bbox_empty || np[r] < bbox_lo[r]) bbox_lo[r] = np[r];
                    if (bbox_empty || np[r] > bbox_hi[r]) bbox_hi[r] = np[r];
                end
                bbox_empty = 1'b0;
                res = '{KIND_VERTEX, vtx, np[0], np[1], np[2], nn[0], nn[1], nn[2], 1'b1};
                expected_words.push_back(res);
            end
        endcase
    endtask

    // Valid stays high after a word is taken so that words can follow back to
    // back; whoever stops sending drops it.
    task automatic send_item(input t_mode mode, input logic [5:0] bone,
                             input logic [3:0] elem, input logic signed [31:0] val,
                             input logic [11:0] vtx, input logic [16:0] wgt,
                             input logic signed [31:0] sp [3],
                             input logic signed [31:0] sn [3]);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {1'b0, sn[2], sn[1], sn[0], sp[2], sp[1], sp[0], wgt, vtx,
                          val, elem, bone};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        skin_predict(mode, bone, elem, val, vtx, wgt, sp, sn);
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
        endcase
    endfunction

    // Random matrix words for one bone; within +-2.0 unless extreme, so that products stay interesting.
    task automatic write_bone(input logic [5:0] bone, input bit extreme);
        logic signed [31:0] z3 [3] = '{0, 0, 0};
        for (int e = 0; e < 12; e++)
            send_item(MODE_PAL_WR, bone, e[3:0], extreme ? rand_word() :
                      $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000,
                      12'($urandom), 17'($urandom), z3, z3);
    endtask

    task automatic send_assign(input logic [5:0] bone, input logic [11:0] vtx,
                               input logic [16:0] wgt);
        logic signed [31:0] sp [3];
        logic signed [31:0] sn [3];
        for (int i = 0; i < 3; i++) begin
            sp[i] = rand_word();
            sn[i] = rand_word();
        end
        send_item(MODE_ASSIGN, bone, 4'($urandom), $urandom, vtx, wgt, sp, sn);
    endtask

    task automatic send_simple(input t_mode mode);
        logic signed [31:0] r3 [3];
        for (int i = 0; i < 3; i++) r3[i] = $urandom;
        send_item(mode, 6'($urandom), 4'($urandom), $urandom, 12'($urandom),
                  17'($urandom), r3, r3);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic signed [31:0] z3 [3] = '{0, 0, 0};
        idle_pct = 0;
        stall_pct = 0;
        send_simple(MODE_REPORT);
        // Identity bone 0, then an extreme bone 63.
        for (int e = 0; e < 12; e++)
            send_item(MODE_PAL_WR, 6'd0, e[3:0],
                      (e % 4 == 0 && e < 9) ? 32'sh10000 : 32'sh0,
                      12'd0, 17'd0, z3, z3);
        write_bone(6'd63, 1'b1);
        // Out-of-range element writes are ignored.
        send_item(MODE_PAL_WR, 6'd0, 4'd15, 32'sh7FFFFFFF, 12'd0, 17'd0, z3, z3);
        send_item(MODE_PAL_WR, 6'd0, 4'd12, 32'sh80000000, 12'd0, 17'd0, z3, z3);
        send_assign(6'd0, 12'd0, 17'h10000);
        send_assign(6'd0, 12'd0, 17'h1FFFF);
        send_assign(6'd63, 12'hFFF, 17'h1FFFF);
        send_assign(6'd63, 12'hFFF, 17'h0);
        send_assign(6'd63, 12'd5, 17'h10000);
        send_simple(MODE_REPORT);
        wait_drained();
    endtask

    // Frames with random content; the pace is set by idle and stall rates.
    task automatic test_frames(input int items, input int idle, input int stall);
        int sent = 0;
        idle_pct = idle;
        stall_pct = stall;
        while (sent < items) begin
            case ($urandom_range(19))
                0: begin
                    send_simple(MODE_FRAME);
                    wait_drained();  // frame clear is long; drain pending output words meanwhile
                end
                1: begin
                    write_bone($urandom_range(1) ? 6'd0 : 6'd63, $urandom_range(1));
                    sent += 11;
                end
                2: send_simple(MODE_PAL_WR);
                3, 4: send_simple(MODE_REPORT);
                default: send_assign($urandom_range(1) ? 6'd0 : 6'd63,
                                     $urandom_range(1) ? 12'($urandom_range(7)) :
                                                         12'($urandom),
                                     $urandom_range(1) ? 17'h10000 : 17'($urandom));
            endcase
            sent++;
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                repeat (8) send_assign(6'd0, 12'($urandom_range(3)), 17'($urandom));
                s_axis_tvalid <= 1'b0;
            end
        join
        wait_drained();
    endtask

    // Receiver side.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    // Output checker.
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{t_kind'(m_axis_tuser), m_axis_tdata[11:0], m_axis_tdata[43:12],
                    m_axis_tdata[75:44], m_axis_tdata[107:76], m_axis_tdata[139:108],
                    m_axis_tdata[171:140], m_axis_tdata[203:172], m_axis_tlast};
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %p", got);
            end else begin
                want = expected_words.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // Watchdog on cycles with no accepted word on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        quiet_cycles = 0;
        hold_off = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        bbox_empty = 1'b1;
        for (int i = 0; i < 3; i++) begin
            bbox_lo[i] = '0;
            bbox_hi[i] = '0;
        end
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_frames(150, 0, 0);
        test_frames(150, 59, 0);
        test_frames(150, 0, 59);
        test_frames(150, 24, 24);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
